// ----- design/csoa_pkg.sv -----
`default_nettype none

package csoa_pkg;

    localparam int ADDR_W              = 20;
    localparam int CNT_W               = 9;
    localparam int CFG_W               = 9;
    localparam int SPAN_W              = 2 * CNT_W;
    localparam int ACTIVE_W            = 5;
    localparam int DEF_CHUNK_SLOTS     = 16;
    localparam int DEF_WINDOW_BITS     = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

    localparam logic [CFG_W-1:0] OBJECT_SIZE_RESET    = 9'd8;
    localparam logic [CFG_W-1:0] CHUNK_CAPACITY_RESET = 9'd256;

    localparam logic CFG_OBJECT_SIZE    = 1'b0;
    localparam logic CFG_CHUNK_CAPACITY = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_PTR = 2'd1;
    localparam logic [1:0] STATUS_NO_SLOT = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] address;
    } alloc_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   object_address;
        logic [1:0]          status;
        logic                chunk_released;
        logic [ACTIVE_W-1:0] active_chunks;
    } alloc_rsp_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_FREE_CHK,
        FSM_SCAN,
        FSM_ALLOC,
        FSM_DONE
    } fsm_state_t;

endpackage

`default_nettype wire

// ----- design/csoa_ram.sv -----
`default_nettype none

module csoa_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- design/csoa_slots.sv -----
`default_nettype none

module csoa_slots #(
    parameter int CHUNK_SLOTS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             set_en,
    input  wire logic                             clr_en,
    input  wire logic [$clog2(CHUNK_SLOTS)-1:0]   idx,
    output logic      [CHUNK_SLOTS-1:0]           active,
    output logic                                  free_found,
    output logic      [$clog2(CHUNK_SLOTS)-1:0]   free_idx,
    output logic      [$clog2(CHUNK_SLOTS+1)-1:0] count
);

    localparam int SLOT_W = $clog2(CHUNK_SLOTS);
    localparam int NUM_W  = $clog2(CHUNK_SLOTS + 1);

    logic [CHUNK_SLOTS-1:0] active_reg;
    logic [NUM_W-1:0]       count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            count_reg  <= '0;
        end
        else if (set_en)
        begin
            active_reg[idx] <= 1'b1;
            count_reg       <= count_reg + NUM_W'(1);
        end
        else if (clr_en)
        begin
            active_reg[idx] <= 1'b0;
            count_reg       <= count_reg - NUM_W'(1);
        end
    end

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = CHUNK_SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign active = active_reg;
    assign count  = count_reg;

endmodule

`default_nettype wire

// ----- design/chunked_small_object_allocator.sv -----
// Chunked small-object pool allocator.
// Requests arrive as items on the in channel (in_valid, in_stall, in_item). Mode 0
// allocates one object and returns its address as slot and byte offset; mode 1 frees the
// object at in_item.address. Every request yields exactly one result item on the out
// channel (out_valid, out_stall, out_item) with status, release flag and the number of
// active chunks after the request.
// One request is processed at a time. A free checks and writes back the entry read at
// acceptance in FSM_FREE_CHK and then moves its result to the output in FSM_DONE.
// An allocation scans the slot RAM one entry per cycle through its single read port,
// writes the chosen entry in FSM_ALLOC if a slot was found, then moves on to FSM_DONE.
// The next request is accepted in the cycle after the result has moved into the output
// register, while that register may still wait on out_stall.
// Configuration is written through cfg_write, cfg_index and cfg_data; the user must write it
// only while no request is in flight, as the block itself does not enforce this.
// Reset clears all active flags and the chunk count and restores object_size to 8 and
// the chunk capacity to 256; the slot RAM needs no clearing pass because an inactive slot
// is always treated as empty. While out_stall is high the result holds, and after one
// further result is computed the block stalls its input until the output drains.
`default_nettype none

module chunked_small_object_allocator #(
    parameter int CHUNK_SLOTS = csoa_pkg::DEF_CHUNK_SLOTS,
    parameter int WINDOW_BITS = csoa_pkg::DEF_WINDOW_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire csoa_pkg::alloc_req_t       in_item,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output csoa_pkg::alloc_rsp_t            out_item,
    input  wire logic                       cfg_write,
    input  wire logic                       cfg_index,
    input  wire logic [csoa_pkg::CFG_W-1:0] cfg_data
);

    import csoa_pkg::*;

    localparam int SLOT_W = $clog2(CHUNK_SLOTS);
    localparam int NUM_W  = $clog2(CHUNK_SLOTS + 1);
    localparam int RAM_W  = 2 * CNT_W;

    localparam logic [ADDR_W-1:0] WIN_MASK = (WINDOW_BITS >= ADDR_W) ? '1 :
        ADDR_W'((64'd1 << WINDOW_BITS) - 64'd1);

    fsm_state_t state_reg, state_next;

    logic [CFG_W-1:0]  object_size_reg;
    logic [CFG_W-1:0]  chunk_capacity_reg;
    logic [SPAN_W-1:0] span_reg;

    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [SLOT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [SLOT_W-1:0] pick_reg, pick_next;
    logic [CNT_W-1:0]  bump_reg, bump_next;
    logic [CNT_W-1:0]  freed_reg, freed_next;
    logic              claim_reg, claim_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              res_rel_reg, res_rel_next;
    logic              out_valid_reg;
    alloc_rsp_t        out_item_reg;

    logic              in_accept;
    logic              load_out;
    logic              ram_wr_en;
    logic [SLOT_W-1:0] ram_wr_addr;
    logic [RAM_W-1:0]  ram_wr_data;
    logic [SLOT_W-1:0] ram_rd_addr;
    logic [RAM_W-1:0]  ram_rd_data;
    logic [CNT_W-1:0]  rd_bump;
    logic [CNT_W-1:0]  rd_freed;

    logic                   trk_set;
    logic                   trk_clr;
    logic [SLOT_W-1:0]      trk_idx;
    logic [CHUNK_SLOTS-1:0] active;
    logic                   free_found;
    logic [SLOT_W-1:0]      free_idx;
    logic [NUM_W-1:0]       count;

    logic [ADDR_W-1:0] in_slot_full;
    logic [ADDR_W-1:0] rq_slot_full;
    logic [ADDR_W-1:0] rq_offset;
    logic              rq_in_range;
    logic [SLOT_W-1:0] rq_slot;
    logic              free_bad;
    logic [CNT_W-1:0]  freed_inc;
    logic              free_release;
    logic              scan_hit;
    logic              scan_last;
    logic [SPAN_W-1:0] alloc_prod;
    logic [ACTIVE_W-1:0] active_sat;

    csoa_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CHUNK_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    csoa_slots #(
        .CHUNK_SLOTS (CHUNK_SLOTS)
    ) u_slots (
        .clk        (clk),
        .rst_n      (rst_n),
        .set_en     (trk_set),
        .clr_en     (trk_clr),
        .idx        (trk_idx),
        .active     (active),
        .free_found (free_found),
        .free_idx   (free_idx),
        .count      (count)
    );

    assign in_stall  = (state_reg != FSM_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign rd_bump  = ram_rd_data[RAM_W-1:CNT_W];
    assign rd_freed = ram_rd_data[CNT_W-1:0];

    assign in_slot_full = in_item.address >> WINDOW_BITS;
    assign rq_slot_full = addr_reg >> WINDOW_BITS;
    assign rq_offset    = addr_reg & WIN_MASK;
    assign rq_in_range  = (32'(rq_slot_full) < CHUNK_SLOTS);
    assign rq_slot      = rq_slot_full[SLOT_W-1:0];

    assign free_bad     = !rq_in_range || !active[rq_slot] ||
                          (rq_offset >= ADDR_W'(span_reg));
    assign freed_inc    = (rd_freed < CNT_MAX) ? rd_freed + CNT_W'(1) : rd_freed;
    assign free_release = (freed_inc == chunk_capacity_reg);

    assign scan_hit  = active[scan_idx_reg] && (rd_bump < chunk_capacity_reg);
    assign scan_last = (scan_idx_reg == SLOT_W'(CHUNK_SLOTS - 1));

    assign alloc_prod = SPAN_W'(bump_reg) * SPAN_W'(object_size_reg);
    assign active_sat = (32'(count) > 32'd31) ? ACTIVE_W'(31) : ACTIVE_W'(count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            object_size_reg    <= OBJECT_SIZE_RESET;
            chunk_capacity_reg <= CHUNK_CAPACITY_RESET;
            span_reg           <= SPAN_W'(OBJECT_SIZE_RESET) *
                                  SPAN_W'(CHUNK_CAPACITY_RESET);
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_OBJECT_SIZE:    object_size_reg    <= cfg_data;
                    CFG_CHUNK_CAPACITY: chunk_capacity_reg <= cfg_data;
                endcase
            end
            span_reg <= SPAN_W'(object_size_reg) * SPAN_W'(chunk_capacity_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        scan_idx_reg   <= scan_idx_next;
        pick_reg       <= pick_next;
        bump_reg       <= bump_next;
        freed_reg      <= freed_next;
        claim_reg      <= claim_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        res_rel_reg    <= res_rel_next;
        if (load_out)
        begin
            out_item_reg.object_address <= res_addr_reg;
            out_item_reg.status         <= res_status_reg;
            out_item_reg.chunk_released <= res_rel_reg;
            out_item_reg.active_chunks  <= active_sat;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (in_item.mode == MODE_FREE) ? FSM_FREE_CHK : FSM_SCAN;
                end
            end
            FSM_FREE_CHK:
            begin
                state_next = FSM_DONE;
            end
            FSM_SCAN:
            begin
                priority if (scan_hit)
                begin
                    state_next = FSM_ALLOC;
                end
                else if (scan_last)
                begin
                    state_next = (chunk_capacity_reg != '0 && free_found) ?
                                 FSM_ALLOC : FSM_DONE;
                end
            end
            FSM_ALLOC:
            begin
                state_next = FSM_DONE;
            end
            FSM_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        addr_next       = addr_reg;
        scan_idx_next   = scan_idx_reg;
        pick_next       = pick_reg;
        bump_next       = bump_reg;
        freed_next      = freed_reg;
        claim_next      = claim_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        res_rel_next    = res_rel_reg;
        load_out        = 1'b0;
        ram_rd_addr     = scan_idx_reg + SLOT_W'(1);
        ram_wr_en       = 1'b0;
        ram_wr_addr     = pick_reg;
        ram_wr_data     = {bump_reg, freed_reg};
        trk_set         = 1'b0;
        trk_clr         = 1'b0;
        trk_idx         = pick_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                addr_next       = in_item.address;
                scan_idx_next   = '0;
                claim_next      = 1'b0;
                res_addr_next   = '0;
                res_status_next = STATUS_OK;
                res_rel_next    = 1'b0;
                ram_rd_addr     = (in_item.mode == MODE_FREE) ?
                                  in_slot_full[SLOT_W-1:0] : '0;
            end
            FSM_FREE_CHK:
            begin
                ram_wr_addr = rq_slot;
                ram_wr_data = {rd_bump, freed_inc};
                trk_idx     = rq_slot;
                if (free_bad)
                begin
                    res_status_next = STATUS_BAD_PTR;
                end
                else if (free_release)
                begin
                    trk_clr      = 1'b1;
                    res_rel_next = 1'b1;
                end
                else
                begin
                    ram_wr_en = 1'b1;
                end
            end
            FSM_SCAN:
            begin
                scan_idx_next = scan_idx_reg + SLOT_W'(1);
                priority if (scan_hit)
                begin
                    pick_next  = scan_idx_reg;
                    bump_next  = rd_bump;
                    freed_next = rd_freed;
                end
                else if (scan_last)
                begin
                    if (chunk_capacity_reg != '0 && free_found)
                    begin
                        pick_next  = free_idx;
                        bump_next  = '0;
                        freed_next = '0;
                        claim_next = 1'b1;
                    end
                    else
                    begin
                        res_status_next = STATUS_NO_SLOT;
                    end
                end
            end
            FSM_ALLOC:
            begin
                res_addr_next = (ADDR_W'(pick_reg) << WINDOW_BITS) |
                                (ADDR_W'(alloc_prod) & WIN_MASK);
                ram_wr_en     = 1'b1;
                ram_wr_data   = {bump_reg + CNT_W'(1), freed_reg};
                trk_set       = claim_reg;
            end
            FSM_DONE:
            begin
                load_out = !out_valid_reg || !out_stall;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/csoa_checker.sv -----
`default_nettype none

module csoa_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire csoa_pkg::alloc_req_t in_item,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire csoa_pkg::alloc_rsp_t out_item
);

    import csoa_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("Stalled result item changed or was dropped.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Block took no busy state after accepting an item.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.status == STATUS_OK || out_item.status == STATUS_BAD_PTR ||
                      out_item.status == STATUS_NO_SLOT)
        else $error("Result item carries an undefined status.");

    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != STATUS_OK |->
            out_item.object_address == '0 && !out_item.chunk_released)
        else $error("Failed request returned an address or a release.");

    a_release_is_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.chunk_released |-> out_item.object_address == '0)
        else $error("Released chunk reported together with an allocated address.");

endmodule

bind chunked_small_object_allocator csoa_checker u_csoa_checker (.*);

`default_nettype wire

// ----- tb/tb_chunked_small_object_allocator.sv -----
`timescale 1ns / 1ps

module tb_chunked_small_object_allocator;

    import csoa_pkg::*;

    localparam int SLOTS = DEF_CHUNK_SLOTS;
    localparam int WIN = DEF_WINDOW_BITS;
    localparam int SLOT_W = ADDR_W - WIN;
    localparam int DRAIN_CYCLES = DEF_CHUNK_SLOTS + 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES = 11;

    logic clk;
    logic rst_n;
    logic in_valid = 1'b0;
    logic in_stall;
    alloc_req_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    alloc_rsp_t out_item;
    logic cfg_write = 1'b0;
    logic cfg_index = CFG_OBJECT_SIZE;
    logic [CFG_W-1:0] cfg_data = '0;

    chunked_small_object_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    int phase_obj [PHASES] = '{8, 16, 24, 1, 0, 511, 256, 100, 12, 256, 40};
    int phase_per [PHASES] = '{256, 1, 2, 3, 4, 200, 511, 0, 5, 1, 7};
    int phase_len [PHASES] = '{100, 100, 120, 120, 60, 180, 80, 40, 150, 80, 200};
    int phase_alloc_pct [PHASES] = '{60, 55, 55, 55, 55, 90, 70, 50, 55, 80, 55};

    logic [ADDR_W:0] directed_reqs [8] = '{
        {MODE_ALLOC, 20'hFFFFF},
        {MODE_ALLOC, 20'h00000},
        {MODE_FREE, 20'h00000},
        {MODE_FREE, 20'h00800},
        {MODE_FREE, 20'h007F8},
        {MODE_FREE, 20'hF0000},
        {MODE_FREE, 20'hFFFFF},
        {MODE_FREE, 20'h0FFFF}
    };

    alloc_req_t pending_requests [$];
    alloc_rsp_t expected_replies [$];
    logic [ADDR_W-1:0] live_objects [$];

    logic pool_active [SLOTS];
    logic [CNT_W-1:0] pool_bump [SLOTS];
    logic [CNT_W-1:0] pool_freed [SLOTS];
    logic [CFG_W-1:0] obj_size;
    logic [CFG_W-1:0] per_chunk;

    int reqs_issued = 0;
    int reqs_accepted = 0;
    int results_seen = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int send_gap = 0;
    int hold_cycles = 0;
    bit idle_on = 1'b1;
    logic in_took = 1'b0;
    logic out_took = 1'b0;

    function automatic alloc_rsp_t serve_request(alloc_req_t req);
        alloc_rsp_t rsp;
        int pick;
        int slot;
        logic [SPAN_W-1:0] offset;
        logic [SPAN_W-1:0] span;
        logic [WIN-1:0] window_off;
        rsp = '0;
        pick = -1;
        if (req.mode == MODE_ALLOC)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (pick < 0 && pool_active[i] && pool_bump[i] < per_chunk)
                    pick = i;
            if (pick < 0 && per_chunk != 0)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (pick < 0 && !pool_active[i])
                    begin
                        pool_active[i] = 1'b1;
                        pool_bump[i] = '0;
                        pool_freed[i] = '0;
                        pick = i;
                    end
                end
            end
            if (pick < 0)
                rsp.status = STATUS_NO_SLOT;
            else
            begin
                offset = pool_bump[pick] * obj_size;
                rsp.object_address = {SLOT_W'(pick), offset[WIN-1:0]};
                pool_bump[pick] = pool_bump[pick] + 1'b1;
                live_objects.push_back(rsp.object_address);
            end
        end
        else
        begin
            slot = int'(req.address >> WIN);
            window_off = req.address[WIN-1:0];
            span = per_chunk * obj_size;
            if (slot >= SLOTS || !pool_active[slot] || SPAN_W'(window_off) >= span)
                rsp.status = STATUS_BAD_PTR;
            else
            begin
                if (pool_freed[slot] < CNT_MAX)
                    pool_freed[slot] = pool_freed[slot] + 1'b1;
                if (pool_freed[slot] == per_chunk)
                begin
                    pool_active[slot] = 1'b0;
                    pool_bump[slot] = '0;
                    pool_freed[slot] = '0;
                    rsp.chunk_released = 1'b1;
                end
            end
        end
        for (int i = 0; i < SLOTS; i++)
            if (pool_active[i])
                rsp.active_chunks = rsp.active_chunks + 1'b1;
        return rsp;
    endfunction

    task automatic push_request(logic mode, logic [ADDR_W-1:0] address);
        alloc_req_t req;
        req.mode = mode;
        req.address = address;
        pending_requests.push_back(req);
        reqs_issued++;
    endtask

    task automatic settle();
        while (reqs_issued != reqs_accepted || expected_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                in_item <= pending_requests.pop_front();
                in_valid <= 1'b1;
                send_gap <= idle_on ? $urandom_range(0, 4) : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // The receiver holds off for a long stretch twice so that the block backs up.
    always @(negedge clk)
    begin
        if (out_took)
        begin
            hold_cycles = idle_on ? $urandom_range(0, 4) : 0;
            if (results_seen == 400 || results_seen == 900)
                hold_cycles = 80;
        end
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : scoreboard
        alloc_rsp_t want;
        in_took <= rst_n && in_valid && !in_stall;
        out_took <= rst_n && out_valid && !out_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_replies.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected item %h", $time, out_item);
            end
            else
            begin
                want = expected_replies.pop_front();
                if (out_item.object_address !== want.object_address)
                begin
                    mismatches++;
                    $display("%0t: object_address expected %h got %h", $time,
                        want.object_address, out_item.object_address);
                end
                if (out_item.status !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d got %0d", $time,
                        want.status, out_item.status);
                end
                if (out_item.chunk_released !== want.chunk_released)
                begin
                    mismatches++;
                    $display("%0t: chunk_released expected %b got %b", $time,
                        want.chunk_released, out_item.chunk_released);
                end
                if (out_item.active_chunks !== want.active_chunks)
                begin
                    mismatches++;
                    $display("%0t: active_chunks expected %0d got %0d", $time,
                        want.active_chunks, out_item.active_chunks);
                end
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            expected_replies.push_back(serve_request(in_item));
            reqs_accepted++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int pick;
        int idx;
        int top_slot;
        logic [ADDR_W-1:0] addr;
        rst_n = 1'b0;
        obj_size = OBJECT_SIZE_RESET;
        per_chunk = CHUNK_CAPACITY_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            pool_active[i] = 1'b0;
            pool_bump[i] = '0;
            pool_freed[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_reqs[i])
            push_request(directed_reqs[i][ADDR_W], directed_reqs[i][ADDR_W-1:0]);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            idle_on = (p % 4) != 3;
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= CFG_OBJECT_SIZE;
            cfg_data <= CFG_W'(phase_obj[p]);
            @(negedge clk);
            cfg_index <= CFG_CHUNK_CAPACITY;
            cfg_data <= CFG_W'(phase_per[p]);
            @(negedge clk);
            cfg_write <= 1'b0;
            obj_size = CFG_W'(phase_obj[p]);
            per_chunk = CFG_W'(phase_per[p]);

            for (int n = 0; n < phase_len[p]; n++)
            begin
                while (reqs_issued - reqs_accepted >= 2)
                    @(negedge clk);
                if ($urandom_range(0, 99) < phase_alloc_pct[p])
                    push_request(MODE_ALLOC, ADDR_W'($urandom));
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70 && live_objects.size() != 0)
                    begin
                        idx = $urandom_range(0, live_objects.size() - 1);
                        addr = live_objects[idx];
                        live_objects.delete(idx);
                    end
                    else if (pick < 85)
                    begin
                        top_slot = $urandom_range(1, SLOTS - 1);
                        addr = {SLOT_W'($urandom_range(0, top_slot)),
                            WIN'($urandom_range(0, int'(per_chunk) + 1) * int'(obj_size))};
                    end
                    else
                        addr = ADDR_W'($urandom);
                    push_request(MODE_FREE, addr);
                end
            end
            settle();
        end

        if (mismatches == 0 && expected_replies.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/csoa_pkg.sv
design/csoa_ram.sv
design/csoa_slots.sv
design/chunked_small_object_allocator.sv
design/csoa_checker.sv
tb/tb_chunked_small_object_allocator.sv
